>>> sv/lfpd_pkg.sv
// shared types and constants of the length framed packet deframer
`default_nettype none

package lfpd_pkg;

	localparam int BYTE_W       = 8;
	localparam int CNT_W        = 6;
	localparam int IDX_W        = 5;
	localparam int MAX_DATA_DEF = 32;
	localparam int MIN_SIZE     = 6;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

	// register indexes on the configuration port
	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic cap_size;
		logic cap_ctx;
		logic cap_addr;
		logic cap_trgt;
		logic wr_data;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_start;
		logic size_ok;
		logic cnt_zero;
		logic data_done;
		logic is_end;
		logic emit_last;
	} sts_t;

endpackage

`default_nettype wire

>>> sv/lfpd_dpath.sv
// datapath: header registers, byte counters, payload memory and result register
`default_nettype none

module lfpd_dpath #(
	parameter int MAX_DATA = lfpd_pkg::MAX_DATA_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [lfpd_pkg::BYTE_W-1:0]   in_byte,
	input  wire logic [lfpd_pkg::BYTE_W-1:0]   start_marker,
	input  wire logic [lfpd_pkg::BYTE_W-1:0]   end_marker,
	input  wire lfpd_pkg::cmd_t                cmd,
	output lfpd_pkg::sts_t                     sts,
	output logic [lfpd_pkg::BYTE_W-1:0]        context_byte,
	output logic [lfpd_pkg::BYTE_W-1:0]        address_byte,
	output logic [lfpd_pkg::BYTE_W-1:0]        target_byte,
	output logic [lfpd_pkg::CNT_W-1:0]         data_count,
	output logic                               has_data,
	output logic [lfpd_pkg::IDX_W-1:0]         data_index,
	output logic [lfpd_pkg::BYTE_W-1:0]        data_value,
	output logic                               last_of_packet
);

	localparam int AW       = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
	localparam int SIZE_MAX = lfpd_pkg::MIN_SIZE + MAX_DATA;
	localparam int CW       = lfpd_pkg::CNT_W;
	localparam int BW       = lfpd_pkg::BYTE_W;

	logic [BW-1:0] ctx_q;
	logic [BW-1:0] addr_q;
	logic [BW-1:0] trgt_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic [BW-1:0] size_diff;
	logic [BW-1:0] mem [MAX_DATA];

	logic [BW-1:0]               out_ctx_q;
	logic [BW-1:0]               out_addr_q;
	logic [BW-1:0]               out_trgt_q;
	logic [CW-1:0]               out_cnt_q;
	logic                        out_has_q;
	logic [lfpd_pkg::IDX_W-1:0]  out_idx_q;
	logic [BW-1:0]               out_data_q;
	logic                        out_last_q;

	// status decode on the incoming byte and counters
	assign size_diff     = in_byte - BW'(lfpd_pkg::MIN_SIZE);
	assign sts.is_start  = (in_byte == start_marker);
	assign sts.is_end    = (in_byte == end_marker);
	assign sts.size_ok   = (in_byte >= BW'(lfpd_pkg::MIN_SIZE)) && (in_byte <= BW'(SIZE_MAX));
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.data_done = ((CW'(wr_idx_q) + CW'(1)) == cnt_q);
	assign sts.emit_last = (cnt_q == '0) || ((CW'(rd_idx_q) + CW'(1)) == cnt_q);

	// header bytes
	always_ff @(posedge clk) begin
		if (cmd.cap_ctx) begin
			ctx_q <= in_byte;
		end
		if (cmd.cap_addr) begin
			addr_q <= in_byte;
		end
		if (cmd.cap_trgt) begin
			trgt_q <= in_byte;
		end
	end

	// data count and write / read pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.cap_size) begin
				cnt_q    <= size_diff[CW-1:0];
				wr_idx_q <= '0;
				rd_idx_q <= '0;
			end
			if (cmd.wr_data) begin
				wr_idx_q <= wr_idx_q + AW'(1);
			end
			if (cmd.load_out) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
	end

	// payload memory write port
	always_ff @(posedge clk) begin
		if (cmd.wr_data) begin
			mem[wr_idx_q] <= in_byte;
		end
	end

	// result register, loaded with the registered memory read
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ctx_q  <= ctx_q;
			out_addr_q <= addr_q;
			out_trgt_q <= trgt_q;
			out_cnt_q  <= cnt_q;
			out_has_q  <= !sts.cnt_zero;
			out_idx_q  <= sts.cnt_zero ? '0 : lfpd_pkg::IDX_W'(rd_idx_q);
			out_data_q <= sts.cnt_zero ? '0 : mem[rd_idx_q];
			out_last_q <= sts.emit_last;
		end
	end

	assign context_byte   = out_ctx_q;
	assign address_byte   = out_addr_q;
	assign target_byte    = out_trgt_q;
	assign data_count     = out_cnt_q;
	assign has_data       = out_has_q;
	assign data_index     = out_idx_q;
	assign data_value     = out_data_q;
	assign last_of_packet = out_last_q;

endmodule

`default_nettype wire

>>> sv/lfpd_ctrl.sv
// controller: framing state machine and result beat valid
`default_nettype none

module lfpd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire lfpd_pkg::sts_t sts,
	output lfpd_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SIZE,
		ST_CTX,
		ST_ADDR,
		ST_TRGT,
		ST_DATA,
		ST_END,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   acc;
	logic   advance;

	assign in_ready  = (state_q != ST_EMIT);
	assign out_valid = out_valid_q;
	assign acc       = in_valid && in_ready;
	assign advance   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// datapath commands
	assign cmd.cap_size = acc && (state_q == ST_SIZE) && sts.size_ok;
	assign cmd.cap_ctx  = acc && (state_q == ST_CTX);
	assign cmd.cap_addr = acc && (state_q == ST_ADDR);
	assign cmd.cap_trgt = acc && (state_q == ST_TRGT);
	assign cmd.wr_data  = acc && (state_q == ST_DATA);
	assign cmd.load_out = advance;

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HUNT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_HUNT: begin
					if (acc && sts.is_start) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					if (acc) begin
						state_q <= sts.size_ok ? ST_CTX : ST_HUNT;
					end
				end
				ST_CTX: begin
					if (acc) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (acc) begin
						state_q <= ST_TRGT;
					end
				end
				ST_TRGT: begin
					if (acc) begin
						state_q <= sts.cnt_zero ? ST_END : ST_DATA;
					end
				end
				ST_DATA: begin
					if (acc && sts.data_done) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					if (acc) begin
						state_q <= sts.is_end ? ST_EMIT : ST_HUNT;
					end
				end
				ST_EMIT: begin
					if (advance && sts.emit_last) begin
						state_q <= ST_HUNT;
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

`ifndef SYNTH
	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

	// a bad closing byte drops the packet
	a_bad_end_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && acc && !sts.is_end) |=> (state_q == ST_HUNT && !out_valid_q)
		|| (state_q == ST_HUNT))
		else $error("packet with bad closing byte not dropped");

	// a loaded result shows valid on the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not marked valid");

	// the run ends with the last beat and then hunting resumes
	a_emit_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && sts.emit_last) |=> (state_q == ST_HUNT))
		else $error("emission did not end after last beat");
`endif

endmodule

`default_nettype wire

>>> sv/length_framed_packet_deframer_top.sv
// Length framed packet deframer. The block hunts for the start marker, reads the
// size, context, address and target bytes, stores up to MAX_DATA data bytes and
// checks the closing byte against the end marker. On a good close the packet
// drains from the payload memory read port at one result beat per cycle while
// out_ready is high (data_count beats, or a single beat without data, the last
// one marked by last_of_packet); rx_byte is not accepted during that drain. Bad
// sizes and bad closing bytes drop the packet with no result. Markers are set
// over the APB port at byte addresses 0 and 4.
`default_nettype none

module length_framed_packet_deframer_top #(
	parameter int MAX_DATA = lfpd_pkg::MAX_DATA_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [lfpd_pkg::BYTE_W-1:0]  rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [lfpd_pkg::BYTE_W-1:0]       context_byte,
	output logic [lfpd_pkg::BYTE_W-1:0]       address_byte,
	output logic [lfpd_pkg::BYTE_W-1:0]       target_byte,
	output logic [lfpd_pkg::CNT_W-1:0]        data_count,
	output logic                              has_data,
	output logic [lfpd_pkg::IDX_W-1:0]        data_index,
	output logic [lfpd_pkg::BYTE_W-1:0]       data_value,
	output logic                              last_of_packet
);

	logic [lfpd_pkg::BYTE_W-1:0] start_marker_q;
	logic [lfpd_pkg::BYTE_W-1:0] end_marker_q;
	logic                        cfg_wr;
	lfpd_pkg::cmd_t              cmd;
	lfpd_pkg::sts_t              sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= lfpd_pkg::START_MARKER_RST;
			end_marker_q   <= lfpd_pkg::END_MARKER_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				lfpd_pkg::REG_START_MARKER: start_marker_q <= pwdata[lfpd_pkg::BYTE_W-1:0];
				lfpd_pkg::REG_END_MARKER:   end_marker_q   <= pwdata[lfpd_pkg::BYTE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[2])
			lfpd_pkg::REG_START_MARKER: prdata = 32'(start_marker_q);
			lfpd_pkg::REG_END_MARKER:   prdata = 32'(end_marker_q);
			default:                    prdata = '0;
		endcase
	end

	lfpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfpd_dpath #(
		.MAX_DATA (MAX_DATA)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_byte        (rx_byte),
		.start_marker   (start_marker_q),
		.end_marker     (end_marker_q),
		.cmd            (cmd),
		.sts            (sts),
		.context_byte   (context_byte),
		.address_byte   (address_byte),
		.target_byte    (target_byte),
		.data_count     (data_count),
		.has_data       (has_data),
		.data_index     (data_index),
		.data_value     (data_value),
		.last_of_packet (last_of_packet)
	);

endmodule

`default_nettype wire

>>> bench/testbench.sv
// self-checking bench for the length framed packet deframer: byte stream in, packet beats out
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXD   = lfpd_pkg::MAX_DATA_DEF;
	localparam int SETTLE = lfpd_pkg::MAX_DATA_DEF + 8;
	localparam int LONG_HOLD = 300;

	typedef enum logic [2:0] {
		FR_HUNT, FR_SIZE, FR_CTX, FR_ADDR, FR_TRGT, FR_DATA, FR_CLOSE
	} frame_phase_t;

	typedef struct packed {
		logic [lfpd_pkg::BYTE_W-1:0] ctx;
		logic [lfpd_pkg::BYTE_W-1:0] addr;
		logic [lfpd_pkg::BYTE_W-1:0] trgt;
		logic [lfpd_pkg::CNT_W-1:0]  cnt;
		logic                        has;
		logic [lfpd_pkg::IDX_W-1:0]  idx;
		logic [lfpd_pkg::BYTE_W-1:0] val;
		logic                        fin;
	} packet_beat_t;

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        psel     = 1'b0;
	logic                        penable  = 1'b0;
	logic                        pwrite   = 1'b0;
	logic [2:0]                  paddr    = '0;
	logic [31:0]                 pwdata   = '0;
	logic                        in_valid = 1'b0;
	logic [lfpd_pkg::BYTE_W-1:0] rx_byte  = '0;
	logic                        out_ready = 1'b0;

	wire logic [31:0]                 prdata;
	wire logic                        pready;
	wire logic                        in_ready;
	wire logic                        out_valid;
	wire logic [lfpd_pkg::BYTE_W-1:0] context_byte;
	wire logic [lfpd_pkg::BYTE_W-1:0] address_byte;
	wire logic [lfpd_pkg::BYTE_W-1:0] target_byte;
	wire logic [lfpd_pkg::CNT_W-1:0]  data_count;
	wire logic                        has_data;
	wire logic [lfpd_pkg::IDX_W-1:0]  data_index;
	wire logic [lfpd_pkg::BYTE_W-1:0] data_value;
	wire logic                        last_of_packet;

	length_framed_packet_deframer_top #(
		.MAX_DATA(MAXD)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.context_byte(context_byte), .address_byte(address_byte),
		.target_byte(target_byte), .data_count(data_count), .has_data(has_data),
		.data_index(data_index), .data_value(data_value),
		.last_of_packet(last_of_packet)
	);

	always #1 clk = ~clk;

	// deframer copy: marker settings and frame state
	logic [lfpd_pkg::BYTE_W-1:0] cfg_start = lfpd_pkg::START_MARKER_RST;
	logic [lfpd_pkg::BYTE_W-1:0] cfg_end   = lfpd_pkg::END_MARKER_RST;
	frame_phase_t                fr_phase  = FR_HUNT;
	logic [7:0]                  fr_size   = '0;
	logic [7:0]                  fr_seen   = '0;
	logic [lfpd_pkg::BYTE_W-1:0] fr_ctx    = '0;
	logic [lfpd_pkg::BYTE_W-1:0] fr_addr   = '0;
	logic [lfpd_pkg::BYTE_W-1:0] fr_trgt   = '0;
	logic [lfpd_pkg::BYTE_W-1:0] fr_store [MAXD];

	packet_beat_t                awaited_beats [$];
	packet_beat_t                beat_want;
	logic [lfpd_pkg::BYTE_W-1:0] rx_backlog [$];

	int  mismatches = 0;
	int  framed_fed = 0;
	bit  rx_taken   = 1'b0;
	int  tx_gap     = 0;
	int  out_stall  = 0;
	int  out_hold   = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;
	bit  calm       = 1'b0;

	task automatic report_mismatch(input string msg);
		mismatches++;
		// keep the log short on a badly broken block
		if (mismatches <= 100)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// advance the frame state by one byte and queue the beats it releases
	task automatic deframe_byte(input logic [lfpd_pkg::BYTE_W-1:0] b);
		int count;
		int k;
		packet_beat_t beat;
		case (fr_phase)
			FR_HUNT: begin
				if (b == cfg_start)
					fr_phase = FR_SIZE;
			end
			FR_SIZE: begin
				if (b < lfpd_pkg::MIN_SIZE || b > lfpd_pkg::MIN_SIZE + MAXD) begin
					fr_phase = FR_HUNT;
				end else begin
					fr_size  = b;
					fr_seen  = '0;
					fr_phase = FR_CTX;
				end
			end
			FR_CTX: begin
				fr_ctx   = b;
				fr_phase = FR_ADDR;
			end
			FR_ADDR: begin
				fr_addr  = b;
				fr_phase = FR_TRGT;
			end
			FR_TRGT: begin
				fr_trgt  = b;
				fr_phase = (fr_size > lfpd_pkg::MIN_SIZE) ? FR_DATA : FR_CLOSE;
			end
			FR_DATA: begin
				if (fr_seen < MAXD)
					fr_store[fr_seen] = b;
				fr_seen = fr_seen + 8'd1;
				if (fr_seen + lfpd_pkg::MIN_SIZE >= fr_size)
					fr_phase = FR_CLOSE;
			end
			default: begin
				fr_phase = FR_HUNT;
				if (b == cfg_end) begin
					count = (fr_size > lfpd_pkg::MIN_SIZE) ? fr_size - lfpd_pkg::MIN_SIZE : 0;
					if (count > MAXD)
						count = MAXD;
					beat.ctx  = fr_ctx;
					beat.addr = fr_addr;
					beat.trgt = fr_trgt;
					if (count == 0) begin
						// header-only packet gives one beat
						beat.cnt = '0;
						beat.has = 1'b0;
						beat.idx = '0;
						beat.val = '0;
						beat.fin = 1'b1;
						awaited_beats.push_back(beat);
					end else begin
						for (k = 0; k < count; k++) begin
							beat.cnt = count[lfpd_pkg::CNT_W-1:0];
							beat.has = 1'b1;
							beat.idx = k[lfpd_pkg::IDX_W-1:0];
							beat.val = fr_store[k];
							beat.fin = (k + 1 == count);
							awaited_beats.push_back(beat);
						end
					end
				end
			end
		endcase
	endtask

	// monitor: input beats feed the prediction, output beats are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
				rx_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (awaited_beats.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing awaited, ctx %0h idx %0d",
						context_byte, data_index));
				end else begin
					beat_want = awaited_beats.pop_front();
					check_field("context_byte", context_byte, beat_want.ctx);
					check_field("address_byte", address_byte, beat_want.addr);
					check_field("target_byte", target_byte, beat_want.trgt);
					check_field("data_count", data_count, beat_want.cnt);
					check_field("has_data", has_data, beat_want.has);
					check_field("data_index", data_index, beat_want.idx);
					check_field("data_value", data_value, beat_want.val);
					check_field("last_of_packet", last_of_packet, beat_want.fin);
				end
			end
		end
	end

	// byte driver with random gaps after accepted beats
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || rx_taken) begin
				rx_taken = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (rx_backlog.size() > 0) begin
					in_valid <= 1'b1;
					rx_byte  <= rx_backlog.pop_front();
					if (tx_idle_on && !calm && $urandom_range(0, 5) == 0)
						tx_gap = $urandom_range(1, 17);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: long hold-off, random stall bursts, otherwise ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_hold > 0) begin
				out_hold--;
				out_ready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else if (rx_idle_on && !calm && $urandom_range(0, 6) == 0) begin
				out_stall = $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// apb write of one marker, then read it back
	task automatic set_marker(input logic idx, input logic [lfpd_pkg::BYTE_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {8'($urandom_range(0, 255)), 16'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == lfpd_pkg::REG_START_MARKER)
			cfg_start = value;
		else
			cfg_end = value;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", prdata, {24'h0, value});
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every byte is taken and every beat is out, then let the block settle
	task automatic drain_and_settle();
		while (rx_backlog.size() != 0 || in_valid || awaited_beats.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// idle-link bytes that never open a packet
	task automatic push_noise(input int n);
		logic [lfpd_pkg::BYTE_W-1:0] nb;
		for (int i = 0; i < n; i++) begin
			nb = 8'($urandom_range(0, 255));
			if (nb == cfg_start)
				nb = ~nb;
			rx_backlog.push_back(nb);
		end
	endtask

	task automatic push_packet(input int ndata, input bit good_close);
		logic [lfpd_pkg::BYTE_W-1:0] sz;
		sz = 8'(ndata + lfpd_pkg::MIN_SIZE);
		rx_backlog.push_back(cfg_start);
		rx_backlog.push_back(sz);
		for (int i = 0; i < 3 + ndata; i++)
			rx_backlog.push_back(8'($urandom_range(0, 255)));
		if (good_close)
			rx_backlog.push_back(cfg_end);
		else
			rx_backlog.push_back(cfg_end ^ 8'($urandom_range(1, 255)));
		framed_fed += ndata + lfpd_pkg::MIN_SIZE;
	endtask

	// mostly well-formed packets of small size, some broken ones
	task automatic random_traffic(input int quota);
		int goal;
		int pick;
		int ndata;
		logic [lfpd_pkg::BYTE_W-1:0] sz;
		goal = framed_fed + quota;
		while (framed_fed < goal) begin
			push_noise($urandom_range(0, 2));
			pick  = $urandom_range(0, 19);
			ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAXD) : $urandom_range(0, 6);
			if (pick < 14) begin
				push_packet(ndata, 1'b1);
			end else if (pick < 16) begin
				push_packet(ndata, 1'b0);
			end else if (pick < 18) begin
				// size outside the legal range
				if ($urandom_range(0, 1))
					sz = 8'($urandom_range(0, lfpd_pkg::MIN_SIZE - 1));
				else
					sz = 8'($urandom_range(lfpd_pkg::MIN_SIZE + MAXD + 1, 255));
				rx_backlog.push_back(cfg_start);
				rx_backlog.push_back(sz);
				framed_fed += 2;
			end else begin
				// stray start marker followed by anything
				rx_backlog.push_back(cfg_start);
				rx_backlog.push_back(8'($urandom_range(0, 255)));
				framed_fed += 2;
			end
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, header-only packet, bad sizes, bad close, markers inside
		rx_backlog = {8'hff, 8'h00,
			8'h02, 8'h06, 8'hff, 8'h00, 8'ha5, 8'h03,
			8'h02, 8'h05,
			8'h02, 8'h27,
			8'h02, 8'h07, 8'h11, 8'h22, 8'h33, 8'hff, 8'h00,
			8'h02, 8'h08, 8'h02, 8'h03, 8'h02, 8'h03, 8'h02, 8'h03};
		drain_and_settle();

		// low and high marker extremes, full-size packet under a long hold-off
		set_marker(lfpd_pkg::REG_START_MARKER, 8'h00);
		set_marker(lfpd_pkg::REG_END_MARKER, 8'hff);
		push_packet(MAXD, 1'b1);
		out_hold = LONG_HOLD;
		random_traffic(5);
		drain_and_settle();

		// swapped extremes, no idling on either side
		set_marker(lfpd_pkg::REG_START_MARKER, 8'hff);
		set_marker(lfpd_pkg::REG_END_MARKER, 8'h00);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		random_traffic(5);
		drain_and_settle();

		// random markers
		set_marker(lfpd_pkg::REG_START_MARKER, 8'($urandom_range(0, 255)));
		set_marker(lfpd_pkg::REG_END_MARKER, 8'($urandom_range(0, 255)));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		random_traffic(5);
		drain_and_settle();

		// start and end marker equal
		set_marker(lfpd_pkg::REG_START_MARKER, 8'h7e);
		set_marker(lfpd_pkg::REG_END_MARKER, 8'h7e);
		random_traffic(5);
		drain_and_settle();

		// final stretch without idling
		set_marker(lfpd_pkg::REG_START_MARKER, 8'($urandom_range(0, 255)));
		set_marker(lfpd_pkg::REG_END_MARKER, 8'($urandom_range(0, 255)));
		calm = 1'b1;
		random_traffic(5);
		drain_and_settle();

		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
